// ===== rtl/rgb_box_mean_3x3_defines.svh =====
// ----------------------------------------------------------------------------
// rgb_box_mean_3x3_defines.svh
// Assertion macros shared by the box mean filter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_MEAN_3X3_DEFINES_SVH
`define RGB_BOX_MEAN_3X3_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define RBM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same check on the block's own clock and reset.
`define RBM_ASSERT_CLK(lbl, prop, msg) `RBM_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/rbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types, constants and arithmetic helpers of the 3x3 box mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rbm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Dimension registers and position counters are 11 bits wide.
  localparam int DIM_W   = 11;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int CHAN_W  = 8;
  localparam int NUM_CH  = 3;
  localparam int PIX_W   = NUM_CH * CHAN_W;
  // Three samples per column, nine per window, plus rounding.
  localparam int CSUM_W  = CHAN_W + 2;
  localparam int TSUM_W  = CHAN_W + 4;
  localparam int PROD_W  = 2 * TSUM_W;

  // floor(t / 9) == (t * 3641) >> 15 for every t below 2**15.
  localparam logic [TSUM_W-1:0] RECIP9       = TSUM_W'(3641);
  localparam int                RECIP9_SHIFT = 15;
  localparam logic [TSUM_W-1:0] ROUND9       = TSUM_W'(4);

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CSUM_W-1:0] csum_t;
  typedef logic [TSUM_W-1:0] tsum_t;
  typedef logic [DIM_W-1:0]  dim_t;

  function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
    dim_t r;
    if (v < DIM_W'(3)) begin
      r = DIM_W'(3);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Rounded sum already applied by caller; divide by nine via reciprocal.
  function automatic chan_t div9(input tsum_t t);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(t) * PROD_W'(RECIP9);
    return prod[RECIP9_SHIFT +: CHAN_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rbm_line_ram.sv =====
// ----------------------------------------------------------------------------
// rbm_line_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbm_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when both ports hit the same entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rgb_box_mean_3x3.sv =====
// ----------------------------------------------------------------------------
// rgb_box_mean_3x3
// 3x3 box mean over a raster-order RGB pixel stream, one pixel per clock unless stalled.
//
// The block takes one pixel per clock, sustained while the output is not
// stalled, and returns the rounded mean (sum + 4) / 9 of each channel for
// every interior centre; border centres give no beat. A result moves through
// stage 1, stage 2 and the output register. Both line stores sit side by side
// in one RAM (one write port, one read port, registered read), and each
// pixel does a read-modify-write of the entry at its column: the read issues
// on accept, the write-back happens when the pixel leaves the next stage,
// and a forwarding register covers a read that meets the write of the same
// entry (frame restarts on consecutive pixels). The RAM needs no clearing
// pass: no result is produced before two rows of the frame have filled it.
// s_axis_tuser marks the first pixel of a frame and restarts the position
// counters; m_axis_tlast marks the last interior result of a frame. Write
// image_width and image_height only while the block is idle; values are
// clamped to 3..1024 on write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_box_mean_3x3_defines.svh"

module rgb_box_mean_3x3 (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // pixel in
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [23:0]                    s_axis_tdata,  // red, green, blue
  input  wire logic                           s_axis_tuser,  // frame_start
  // mean out
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [23:0]                    m_axis_tdata,  // red_mean, green_mean, blue_mean
  output logic                                m_axis_tlast,  // frame_end
  // register writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rbm_pkg::DIM_W-1:0]      cfg_data_i
);

  import rbm_pkg::*;

  localparam dim_t MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam dim_t MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  // ---------------------------------------------------------------- config
  dim_t width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MAX_W_DIM;
      height_q <= MAX_H_DIM;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= clamp_dim(cfg_data_i, MAX_W_DIM);
        CFG_IMAGE_HEIGHT: height_q <= clamp_dim(cfg_data_i, MAX_H_DIM);
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------- handshake chain
  logic acc, adv1, adv2;
  logic v1_q, v2_q, vo_q;
  logic rdy1, rdy2, rdy_out;

  assign rdy_out       = !vo_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy_out;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign adv1          = v1_q && rdy2;
  assign adv2          = v2_q && rdy_out;

  // -------------------------------------------------------- position logic
  dim_t col_q, row_q;
  dim_t col_base, row_base, row_inc;
  dim_t col_cur, row_cur, col_nxt, row_nxt, row_p1;
  logic emit_cur, fend_cur;

  // Restart on frame_start, wrap a column left past a shrunk width, then
  // place the pixel and work out where the next one lands.
  always_comb begin
    col_base = s_axis_tuser ? '0 : col_q;
    row_base = s_axis_tuser ? '0 : row_q;
    if (col_base >= width_q) begin
      col_cur = '0;
      row_inc = row_base + DIM_W'(1);
    end else begin
      col_cur = col_base;
      row_inc = row_base;
    end
    row_cur = (row_inc >= height_q) ? '0 : row_inc;

    row_p1  = row_cur + DIM_W'(1);
    col_nxt = col_cur + DIM_W'(1);
    row_nxt = row_cur;
    if (col_nxt >= width_q) begin
      col_nxt = '0;
      row_nxt = (row_p1 >= height_q) ? '0 : row_p1;
    end

    emit_cur = (col_cur >= DIM_W'(2)) && (row_cur >= DIM_W'(2));
    fend_cur = (row_cur == height_q - DIM_W'(1)) && (col_cur == width_q - DIM_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_nxt;
      row_q <= row_nxt;
    end
  end

  // ---------------------------------------------------- line store RAM
  // Entry layout: upper row pixel in the high half, middle row in the low.
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  addr1_q;
  logic [2*PIX_W-1:0] rd_data, wr_data, eff1;
  logic [2*PIX_W-1:0] fwd_data_q;
  logic               fwd1_q;
  pix_t               px1_q, top1, mid1;
  logic               emit1_q, fend1_q;

  assign rd_addr = col_cur[ADDR_W-1:0];

  rbm_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * PIX_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (addr1_q),
    .wdata_i (wr_data),
    .re_i    (acc),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Stage 1 picks the forwarded copy when its read met the write of the
  // same entry; otherwise the RAM output is current.
  assign eff1    = fwd1_q ? fwd_data_q : rd_data;
  assign top1    = eff1[2*PIX_W-1:PIX_W];
  assign mid1    = eff1[PIX_W-1:0];
  assign wr_data = {mid1, px1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px1_q      <= s_axis_tdata;
      addr1_q    <= rd_addr;
      emit1_q    <= emit_cur;
      fend1_q    <= fend_cur;
      fwd1_q     <= adv1 && (addr1_q == rd_addr);
      fwd_data_q <= wr_data;
    end
  end

  // ------------------------------------------------------ window and sums
  // The window keeps per-channel column sums of the two previous columns.
  csum_t cs_a_q [NUM_CH];
  csum_t cs_b_q [NUM_CH];
  csum_t cs_new [NUM_CH];
  tsum_t tot    [NUM_CH];
  tsum_t tot2_q [NUM_CH];
  logic  fend2_q;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cs_new[ch] = CSUM_W'(top1[ch*CHAN_W +: CHAN_W])
                 + CSUM_W'(mid1[ch*CHAN_W +: CHAN_W])
                 + CSUM_W'(px1_q[ch*CHAN_W +: CHAN_W]);
      tot[ch]    = TSUM_W'(cs_a_q[ch]) + TSUM_W'(cs_b_q[ch])
                 + TSUM_W'(cs_new[ch]) + ROUND9;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        cs_a_q[ch] <= '0;
        cs_b_q[ch] <= '0;
      end
    end else if (adv1) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        cs_a_q[ch] <= cs_b_q[ch];
        cs_b_q[ch] <= cs_new[ch];
      end
    end
  end

  // Stage 2: only interior centres go on; border pixels drop here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= adv1 && emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        tot2_q[ch] <= tot[ch];
      end
      fend2_q <= fend1_q;
    end
  end

  // ------------------------------------------------------- output register
  logic [PIX_W-1:0] mean_q;
  logic             last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_out) begin
      vo_q <= adv2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        mean_q[ch*CHAN_W +: CHAN_W] <= div9(tot2_q[ch]);
      end
      last_q <= fend2_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = mean_q;
  assign m_axis_tlast  = last_q;

  // ------------------------------------------------------------ assertions
  `RBM_ASSERT_CLK(a_stall_only_when_full, !s_axis_tready |-> (v1_q && v2_q && vo_q && !m_axis_tready), "input stalled with a free stage")
  `RBM_ASSERT_CLK(a_stage2_from_interior, $rose(v2_q) |-> $past(v1_q && emit1_q), "stage 2 filled without an interior pixel")
  `RBM_ASSERT_CLK(a_frame_end_is_interior, (adv1 && fend1_q) |-> emit1_q, "frame end flagged on a border pixel")

endmodule

`default_nettype wire
